[hdl/wpfh_pkg.sv]
// shared constants, types and helper functions for the prime factor histogram
package wpfh_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int PRIME_LIMIT = 256;
  localparam int COUNT_BITS  = 20;

  localparam int IN_VALUE_BITS = 16;
  localparam int WEIGHT_BITS   = 20;
  localparam int OUT_BITS      = 20;

  localparam int DIV_BITS  = $clog2(PRIME_LIMIT);
  localparam int STEP_BITS = $clog2(VALUE_BITS);
  localparam int SUM_BITS  = ((COUNT_BITS > WEIGHT_BITS) ? COUNT_BITS : WEIGHT_BITS) + 1;
  localparam int SQ_BITS   = (2 * DIV_BITS > VALUE_BITS + 1) ? 2 * DIV_BITS : VALUE_BITS + 1;
  localparam int CMP_BITS  = (DIV_BITS > VALUE_BITS) ? DIV_BITS : VALUE_BITS;

  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [DIV_BITS-1:0]    divisor_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [OUT_BITS-1:0]    out_count_t;

  localparam logic [SUM_BITS-1:0] COUNT_MAX = SUM_BITS'((64'd1 << COUNT_BITS) - 64'd1);

  // sieve over all divisor candidates, evaluated at elaboration
  function automatic logic [PRIME_LIMIT-1:0] prime_mask();
    logic [PRIME_LIMIT-1:0] m;
    m    = '1;
    m[0] = 1'b0;
    m[1] = 1'b0;
    for (int i = 2; i < PRIME_LIMIT; i++) begin
      if (m[i]) begin
        for (int j = 2 * i; j < PRIME_LIMIT; j += i) begin
          m[j] = 1'b0;
        end
      end
    end
    return m;
  endfunction

  localparam logic [PRIME_LIMIT-1:0] PRIME_MASK = prime_mask();

  function automatic count_t sat_add(count_t c, weight_t w);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(c) + SUM_BITS'(w);
    if (s > COUNT_MAX) begin
      s = COUNT_MAX;
    end
    return s[COUNT_BITS-1:0];
  endfunction

  function automatic out_count_t to_out(count_t c);
    logic [SUM_BITS-1:0] e;
    e = SUM_BITS'(c);
    return e[OUT_BITS-1:0];
  endfunction

  typedef struct packed {
    logic     start;
    value_t   dividend;
    divisor_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    logic   rem_zero;
  } div_res_t;

  typedef struct packed {
    logic    valid;
    value_t  addr;
    weight_t weight;
  } hist_req_t;

  typedef struct packed {
    logic   ready;
    count_t largest;
  } hist_sts_t;

endpackage

[hdl/wpfh_in_if.sv]
// input channel: value and weight with valid/ready
interface wpfh_in_if;
  logic                                valid;
  logic                                ready;
  logic [wpfh_pkg::IN_VALUE_BITS-1:0]  value;
  logic [wpfh_pkg::WEIGHT_BITS-1:0]    weight;

  modport source (output valid, value, weight, input ready);
  modport sink (input valid, value, weight, output ready);
endinterface

[hdl/wpfh_out_if.sv]
// result channel: running maximum and ones total with valid/ready
interface wpfh_out_if;
  logic                          valid;
  logic                          ready;
  logic [wpfh_pkg::OUT_BITS-1:0] max_count;
  logic [wpfh_pkg::OUT_BITS-1:0] ones_count;

  modport source (output valid, max_count, ones_count, input ready);
  modport sink (input valid, max_count, ones_count, output ready);
endinterface

[hdl/wpfh_div.sv]
// shared restoring divider, one quotient bit per cycle
module wpfh_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpfh_pkg::div_req_t req_i,
  output wpfh_pkg::div_res_t res_o
);

  localparam logic [wpfh_pkg::STEP_BITS-1:0] LAST_STEP =
    wpfh_pkg::STEP_BITS'(wpfh_pkg::VALUE_BITS - 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [wpfh_pkg::STEP_BITS-1:0]    cnt_q, cnt_d;
  wpfh_pkg::divisor_t                rem_q, rem_d;
  wpfh_pkg::value_t                  quo_q, quo_d;
  wpfh_pkg::divisor_t                dvs_q, dvs_d;
  logic [wpfh_pkg::DIV_BITS:0]       trial;
  logic [wpfh_pkg::DIV_BITS:0]       diff;
  logic                              fits;

  assign trial = {rem_q, quo_q[wpfh_pkg::VALUE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[wpfh_pkg::DIV_BITS-1:0] : trial[wpfh_pkg::DIV_BITS-1:0];
      quo_d = {quo_q[wpfh_pkg::VALUE_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.rem_zero = (rem_q == '0);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held more than one cycle");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == LAST_STEP) |=> (done_q && !busy_q))
    else $error("divider did not finish after last step");

endmodule

[hdl/wpfh_hist.sv]
// histogram store with clearing sweep, saturating update and running maximum
module wpfh_hist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpfh_pkg::hist_req_t req_i,
  output wpfh_pkg::hist_sts_t sts_o
);

  localparam int DEPTH = 1 << wpfh_pkg::VALUE_BITS;

  localparam logic [1:0] H_CLEAR = 2'd0;
  localparam logic [1:0] H_IDLE  = 2'd1;
  localparam logic [1:0] H_UPD   = 2'd2;

  logic [1:0]          state_q, state_d;
  wpfh_pkg::value_t    clr_q, clr_d;
  wpfh_pkg::value_t    addr_q, addr_d;
  wpfh_pkg::weight_t   w_q, w_d;
  wpfh_pkg::count_t    largest_q, largest_d;
  wpfh_pkg::count_t    rdata_q;
  wpfh_pkg::count_t    sum;
  logic                we;
  wpfh_pkg::value_t    waddr;
  wpfh_pkg::count_t    wdata;

  wpfh_pkg::count_t    mem [DEPTH];

  assign sum = wpfh_pkg::sat_add(rdata_q, w_q);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    addr_d    = addr_q;
    w_d       = w_q;
    largest_d = largest_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = sum;
    unique case (state_q)
      H_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = H_IDLE;
        end
      end
      H_IDLE: begin
        if (req_i.valid) begin
          addr_d  = req_i.addr;
          w_d     = req_i.weight;
          state_d = H_UPD;
        end
      end
      H_UPD: begin
        we = 1'b1;
        if (sum > largest_q) begin
          largest_d = sum;
        end
        state_d = H_IDLE;
      end
      default: state_d = H_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= H_CLEAR;
      clr_q     <= '0;
      largest_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      largest_q <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    w_q    <= w_d;
  end

  // read lands in rdata_q while the request is taken, update writes next cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign sts_o.ready   = (state_q == H_IDLE);
  assign sts_o.largest = largest_q;

  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    largest_q >= $past(largest_q))
    else $error("running maximum decreased");

  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == H_UPD) |-> (sum >= rdata_q))
    else $error("count update wrapped");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != H_CLEAR) |=> (state_q != H_CLEAR))
    else $error("clearing sweep restarted without reset");

endmodule

[hdl/weighted_prime_factor_histogram.sv]
// top level: trial division sequencer, ones total and result register
//
//   channel   dir  handshake     payload
//   item_i    in   valid/ready   value[15:0], weight[19:0]
//   result_o  out  valid/ready   max_count[19:0], ones_count[19:0]
//
// a value of 0 or 1 skips trial division; otherwise each composite divisor up to the stop
// point is only checked, each prime divisor runs 16 steps on the shared divider, and each
// exact division runs the divider again on the same divisor.
// after reset all 65536 entries of the store are swept to zero before item_i.ready rises.
// the result register lets a new item start while the previous result waits.
module weighted_prime_factor_histogram (
  input  logic   clk_i,
  input  logic   rst_ni,
  wpfh_in_if.sink     item_i,
  wpfh_out_if.source  result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ONES  = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_LEFT  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam wpfh_pkg::divisor_t FIRST_DIV = wpfh_pkg::divisor_t'(2);
  localparam wpfh_pkg::divisor_t LAST_DIV  =
    wpfh_pkg::divisor_t'(wpfh_pkg::PRIME_LIMIT - 1);
  localparam wpfh_pkg::value_t   VALUE_ONE = wpfh_pkg::value_t'(1);

  logic [2:0]               state_q, state_d;
  wpfh_pkg::value_t         n_q, n_d;
  wpfh_pkg::value_t         n0_q, n0_d;
  wpfh_pkg::weight_t        w_q, w_d;
  wpfh_pkg::divisor_t       d_q, d_d;
  logic                     hit_q, hit_d;
  wpfh_pkg::count_t         ones_q, ones_d;
  logic                     out_valid_q, out_valid_d;
  wpfh_pkg::out_count_t     out_max_q, out_max_d;
  wpfh_pkg::out_count_t     out_ones_q, out_ones_d;

  wpfh_pkg::div_req_t       div_req;
  wpfh_pkg::div_res_t       div_res;
  wpfh_pkg::hist_req_t      hist_req;
  wpfh_pkg::hist_sts_t      hist_sts;

  wpfh_pkg::value_t         in_n;
  logic                     item_ready;
  logic [wpfh_pkg::SQ_BITS-1:0] d_sq;
  logic [wpfh_pkg::SQ_BITS-1:0] root_lim;
  logic                     past_root;
  logic                     past_n;

  wpfh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  wpfh_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .sts_o  (hist_sts)
  );

  assign in_n       = wpfh_pkg::VALUE_BITS'(item_i.value);
  assign item_ready = (state_q == S_IDLE) && hist_sts.ready;

  // d > floor(sqrt(n0 + 1)) is the same as d * d > n0 + 1
  assign d_sq      = wpfh_pkg::SQ_BITS'(d_q) * wpfh_pkg::SQ_BITS'(d_q);
  assign root_lim  = wpfh_pkg::SQ_BITS'(n0_q) + 1'b1;
  assign past_root = d_sq > root_lim;
  assign past_n    = wpfh_pkg::CMP_BITS'(d_q) > wpfh_pkg::CMP_BITS'(n_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    n0_d        = n0_q;
    w_d         = w_q;
    d_d         = d_q;
    hit_d       = hit_q;
    ones_d      = ones_q;
    out_valid_d = out_valid_q;
    out_max_d   = out_max_q;
    out_ones_d  = out_ones_q;

    div_req.start    = 1'b0;
    div_req.dividend = n_q;
    div_req.divisor  = d_q;

    hist_req.valid  = 1'b0;
    hist_req.addr   = wpfh_pkg::VALUE_BITS'(d_q);
    hist_req.weight = w_q;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_i.valid && item_ready) begin
          n_d   = in_n;
          n0_d  = in_n;
          w_d   = item_i.weight;
          d_d   = FIRST_DIV;
          hit_d = 1'b0;
          if (in_n == '0) begin
            state_d = S_OUT;
          end else if (in_n == VALUE_ONE) begin
            state_d = S_ONES;
          end else begin
            state_d = S_TEST;
          end
        end
      end
      S_ONES: begin
        ones_d  = wpfh_pkg::sat_add(ones_q, w_q);
        state_d = S_OUT;
      end
      S_TEST: begin
        if (wpfh_pkg::PRIME_MASK[d_q]) begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.rem_zero) begin
            n_d = div_res.quotient;
            // count each distinct factor once, then keep dividing it out
            if (!hit_q) begin
              hist_req.valid = 1'b1;
              hit_d          = 1'b1;
            end
            state_d = S_TEST;
          end else begin
            hit_d   = 1'b0;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (past_n || past_root || d_q == LAST_DIV) begin
          state_d = S_LEFT;
        end else begin
          d_d     = d_q + 1'b1;
          state_d = S_TEST;
        end
      end
      S_LEFT: begin
        if (hist_sts.ready) begin
          if (n_q > VALUE_ONE) begin
            hist_req.valid = 1'b1;
            hist_req.addr  = n_q;
          end
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (hist_sts.ready) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_max_d   = wpfh_pkg::to_out(hist_sts.largest);
          out_ones_d  = wpfh_pkg::to_out(ones_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_q       <= 1'b0;
      ones_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      ones_q      <= ones_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    n0_q       <= n0_d;
    w_q        <= w_d;
    d_q        <= d_d;
    out_max_q  <= out_max_d;
    out_ones_q <= out_ones_d;
  end

  assign item_i.ready        = item_ready;
  assign result_o.valid      = out_valid_q;
  assign result_o.max_count  = out_max_q;
  assign result_o.ones_count = out_ones_q;

  a_bump_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_req.valid |-> hist_sts.ready)
    else $error("histogram update issued while store busy");

  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV))
    else $error("divider finished outside of wait state");

  a_prime_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_res.done && div_res.rem_zero) |->
      wpfh_pkg::PRIME_MASK[d_q])
    else $error("composite divisor divided the remaining value");

endmodule
